// ===== hw/rtl/lrgbok_pkg.sv =====
// ----------------------------------------------------------------------------
// lrgbok_pkg: shared types and constants
// Pixel and result structs, matrix coefficients and widths for the
// linear RGB to OKLab converter.
// ----------------------------------------------------------------------------
package lrgbok_pkg;

	// Field widths
	localparam int unsigned ChanW  = 16;
	localparam int unsigned WideW  = 17;   // Q1.16 channel, 1.0 = 65536
	localparam int unsigned ConeCW = 24;   // unsigned Q0.24 coefficients
	localparam int unsigned ProdW  = ConeCW + WideW;
	localparam int unsigned ConeW  = ProdW + 2;
	localparam int unsigned RootFracBits = 20;
	localparam int unsigned RootW  = RootFracBits + 1;
	localparam int unsigned RadW   = 3 * RootW;          // radicand, padded to digit groups
	localparam int unsigned RemW   = 48;
	localparam int unsigned SqW    = 2 * RootW + 2;
	localparam int unsigned LabCW  = 27;   // signed Q.24 coefficients
	localparam int unsigned LabPW  = LabCW + RootW + 1;
	localparam int unsigned LabSW  = LabPW + 2;
	localparam int unsigned OutShift = 30;

	localparam int unsigned DefRootStages = RootW;

	typedef struct packed {
		logic [ChanW-1:0] red_linear;
		logic [ChanW-1:0] green_linear;
		logic [ChanW-1:0] blue_linear;
	} pixel_t;

	typedef struct packed {
		logic signed [ChanW-1:0] lightness;
		logic signed [ChanW-1:0] green_red_axis;
		logic signed [ChanW-1:0] blue_yellow_axis;
	} lab_t;

	typedef logic [ConeCW-1:0] cone_coef_t;
	typedef logic signed [LabCW-1:0] lab_coef_t;

	// RGB to cone response matrix
	localparam cone_coef_t ConeMat [0:2][0:2] = '{
		'{24'd6915929, 24'd8998167, 24'd863121},
		'{24'd3555151, 24'd11420243, 24'd1801822},
		'{24'd1481469, 24'd4726458, 24'd10569289}
	};

	// Cone roots to Lab matrix
	localparam lab_coef_t LabMat [0:2][0:2] = '{
		'{27'sd3530836, 27'sd13314697, -27'sd68318},
		'{27'sd33185308, -27'sd40745016, 27'sd7559708},
		'{27'sd434598, 27'sd13132731, -27'sd13567328}
	};

endpackage

// ===== hw/rtl/linear_rgb_to_oklab.sv =====
// ----------------------------------------------------------------------------
// linear_rgb_to_oklab: linear RGB pixel to OKLab converter
// Matrix to cone responses, digit-by-digit pipelined cube root, matrix to
// L, a, b with rounding and saturation.
// ----------------------------------------------------------------------------
//  channel  | ports                 | transfer
//  ---------+-----------------------+------------------------------------
//  pixel in | start, busy, pixel    | edge with start high and busy low
//  result   | done, lab             | done high for one cycle, no stall
//
// One pixel may enter every cycle; busy stays low.
// Registered stages in order: widen, cone products, cone sums, one
// cube root digit per stage, Lab products, Lab sum and saturation.
// Reset clears only the valid bits; data registers are left as they are.
// The receiver cannot stall, so nothing is ever held back.
module linear_rgb_to_oklab (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  lrgbok_pkg::pixel_t pixel,
	output logic               done,
	output lrgbok_pkg::lab_t   lab
);

	// one root digit per stage, tied to the radicand width
	localparam int unsigned RootStages = lrgbok_pkg::DefRootStages;

	localparam int unsigned WideW = lrgbok_pkg::WideW;
	localparam int unsigned ProdW = lrgbok_pkg::ProdW;
	localparam int unsigned ConeW = lrgbok_pkg::ConeW;
	localparam int unsigned RadW  = lrgbok_pkg::RadW;
	localparam int unsigned RemW  = lrgbok_pkg::RemW;
	localparam int unsigned SqW   = lrgbok_pkg::SqW;
	localparam int unsigned RootW = lrgbok_pkg::RootW;
	localparam int unsigned LabPW = lrgbok_pkg::LabPW;
	localparam int unsigned LabSW = lrgbok_pkg::LabSW;
	localparam int unsigned ChanW = lrgbok_pkg::ChanW;
	localparam int unsigned RndW  = LabSW - lrgbok_pkg::OutShift;

	assign busy = 1'b0;

	// Stage 1: widen channels to Q1.16 with 1.0 exact
	logic             v_s1;
	logic [WideW-1:0] x_s1 [0:2];
	logic [ChanW-1:0] chan [0:2];
	assign chan[0] = pixel.red_linear;
	assign chan[1] = pixel.green_linear;
	assign chan[2] = pixel.blue_linear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			x_s1[i] <= {1'b0, chan[i]} + {{ChanW{1'b0}}, chan[i][ChanW-1]};
	end

	// Stage 2: cone products
	logic             v_s2;
	logic [ProdW-1:0] cp_s2 [0:2][0:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				cp_s2[i][j] <= lrgbok_pkg::ConeMat[i][j] * x_s1[j];
	end

	// Stage 3: cone sums, shifted into the radicand
	logic             v_s3;
	logic [RadW-1:0]  rad_s3 [0:2];
	logic [ConeW-1:0] cone_sum [0:2];
	always_comb begin
		for (int i = 0; i < 3; i++)
			cone_sum[i] = ConeW'(cp_s2[i][0]) + ConeW'(cp_s2[i][1]) + ConeW'(cp_s2[i][2]);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			rad_s3[i] <= RadW'({cone_sum[i], {lrgbok_pkg::RootFracBits{1'b0}}});
	end

	// Cube root: one digit per stage; remainder and root square kept alongside
	logic            cr_v_s   [0:RootStages];
	logic [RadW-1:0] cr_rad_s [0:RootStages][0:2];
	logic [RemW-1:0] cr_rem_s [0:RootStages][0:2];
	logic [RootW-1:0] cr_y_s  [0:RootStages][0:2];
	logic [SqW-1:0]  cr_sq_s  [0:RootStages][0:2];

	always_comb begin
		cr_v_s[0] = v_s3;
		for (int i = 0; i < 3; i++) begin
			cr_rad_s[0][i] = rad_s3[i];
			cr_rem_s[0][i] = '0;
			cr_y_s[0][i]   = '0;
			cr_sq_s[0][i]  = '0;
		end
	end

	for (genvar k = 0; k < RootStages; k++) begin : g_root
		localparam int unsigned Lsb = 3 * (RootStages - 1 - k);
		logic [RemW-1:0]  r_sh [0:2];
		logic [RemW-1:0]  trial [0:2];
		logic [RemW-1:0]  sq_w [0:2];
		logic [RemW-1:0]  y_w [0:2];
		logic             take [0:2];

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				sq_w[i]  = RemW'(cr_sq_s[k][i]);
				y_w[i]   = RemW'(cr_y_s[k][i]);
				r_sh[i]  = {cr_rem_s[k][i][RemW-4:0], cr_rad_s[k][i][Lsb+2:Lsb]};
				trial[i] = (sq_w[i] << 3) + (sq_w[i] << 2) + (y_w[i] << 2) + (y_w[i] << 1)
					+ RemW'(1);
				take[i]  = (r_sh[i] >= trial[i]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cr_v_s[k+1] <= 1'b0;
			else cr_v_s[k+1] <= cr_v_s[k];
		end
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				cr_rad_s[k+1][i] <= cr_rad_s[k][i];
				cr_rem_s[k+1][i] <= take[i] ? r_sh[i] - trial[i] : r_sh[i];
				cr_y_s[k+1][i]   <= {cr_y_s[k][i][RootW-2:0], take[i]};
				cr_sq_s[k+1][i]  <= take[i]
					? SqW'((sq_w[i] << 2) + (y_w[i] << 2) + RemW'(1))
					: SqW'(sq_w[i] << 2);
			end
		end
	end

	// Lab products
	logic                    v_lp_s;
	logic signed [LabPW-1:0] lp_s [0:2][0:2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_lp_s <= 1'b0;
		else v_lp_s <= cr_v_s[RootStages];
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				lp_s[i][j] <= LabPW'(lrgbok_pkg::LabMat[i][j]
					* $signed({1'b0, cr_y_s[RootStages][j]}));
	end

	// Lab sums, round to Q2.14, saturate
	logic signed [LabSW-1:0] lsum [0:2];
	logic signed [RndW-1:0]  lrnd [0:2];
	logic signed [ChanW-1:0] lsat [0:2];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lsum[i] = LabSW'(lp_s[i][0]) + LabSW'(lp_s[i][1]) + LabSW'(lp_s[i][2])
				+ (LabSW'(1) <<< (lrgbok_pkg::OutShift - 1));
			lrnd[i] = RndW'(lsum[i] >>> lrgbok_pkg::OutShift);
			if (lrnd[i] > RndW'(32767)) lsat[i] = 16'sh7FFF;
			else if (lrnd[i] < -RndW'(32768)) lsat[i] = -16'sh8000;
			else lsat[i] = lrnd[i][ChanW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_lp_s;
	end
	always_ff @(posedge clk) begin
		lab.lightness        <= lsat[0];
		lab.green_red_axis   <= lsat[1];
		lab.blue_yellow_axis <= lsat[2];
	end

endmodule

// ===== bench/linear_rgb_to_oklab_test.sv =====
// ----------------------------------------------------------------------------
// linear_rgb_to_oklab_test: self-checking bench for the OKLab converter
// Drives pixels through the start/busy command port, predicts each Lab
// result with an independent fixed-point model and compares it field by
// field against the done-strobed output, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_rgb_to_oklab_test;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	lrgbok_pkg::pixel_t pixel;
	logic               done;
	lrgbok_pkg::lab_t   lab;

	lrgbok_pkg::lab_t   lab_queue[$];
	int                 fail_count;
	bit                 idle_on;

	linear_rgb_to_oklab u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.pixel  (pixel),
		.done   (done),
		.lab    (lab)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// exact floor cube root of acc * 2^20, bit by bit
	function automatic logic [20:0] cbrt_q20(logic [63:0] acc);
		logic [63:0] rad;
		logic [63:0] y;
		logic [63:0] t;
		rad = acc << 20;
		y = 0;
		for (int b = 20; b >= 0; b--) begin
			t = y | (64'd1 << b);
			if (t * t * t <= rad)
				y = t;
		end
		return y[20:0];
	endfunction

	// full pixel -> Lab prediction
	function automatic lrgbok_pkg::lab_t oklab_of(lrgbok_pkg::pixel_t p);
		logic [63:0]        wide [3];
		logic [63:0]        cone;
		logic signed [63:0] root [3];
		logic signed [63:0] acc;
		logic signed [63:0] q [3];
		lrgbok_pkg::lab_t   r;
		wide[0] = p.red_linear + (p.red_linear >> 15);
		wide[1] = p.green_linear + (p.green_linear >> 15);
		wide[2] = p.blue_linear + (p.blue_linear >> 15);
		for (int i = 0; i < 3; i++) begin
			cone = 0;
			for (int j = 0; j < 3; j++)
				cone += 64'(lrgbok_pkg::ConeMat[i][j]) * wide[j];
			root[i] = $signed({43'd0, cbrt_q20(cone)});
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += 64'(lrgbok_pkg::LabMat[i][j]) * root[j];
			// arithmetic shift floors, for the rounding add
			acc = (acc + (64'sd1 <<< 29)) >>> 30;
			if (acc > 32767) acc = 32767;
			else if (acc < -32768) acc = -32768;
			q[i] = acc;
		end
		r.lightness        = q[0][15:0];
		r.green_red_axis   = q[1][15:0];
		r.blue_yellow_axis = q[2][15:0];
		return r;
	endfunction

	// one transfer, with an optional random idle burst before it
	task automatic send_pixel(lrgbok_pkg::pixel_t p);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy);
		lab_queue.push_back(oklab_of(p));
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (lab_queue.size() == 0) begin
				$error("unexpected result %h", lab);
				fail_count++;
			end else begin
				lrgbok_pkg::lab_t e;
				e = lab_queue.pop_front();
				if (lab.lightness !== e.lightness) begin
					$error("lightness exp %0d got %0d", e.lightness, lab.lightness);
					fail_count++;
				end
				if (lab.green_red_axis !== e.green_red_axis) begin
					$error("green_red_axis exp %0d got %0d", e.green_red_axis,
						lab.green_red_axis);
					fail_count++;
				end
				if (lab.blue_yellow_axis !== e.blue_yellow_axis) begin
					$error("blue_yellow_axis exp %0d got %0d", e.blue_yellow_axis,
						lab.blue_yellow_axis);
					fail_count++;
				end
			end
		end
	end

	function automatic lrgbok_pkg::pixel_t rgb(int r, int g, int b);
		lrgbok_pkg::pixel_t p;
		p.red_linear   = r[15:0];
		p.green_linear = g[15:0];
		p.blue_linear  = b[15:0];
		return p;
	endfunction

	// black, white, primaries, secondaries, half-scale and single bits
	task automatic test_corners();
		int v [6] = '{0, 1, 32767, 32768, 65534, 65535};
		send_pixel(rgb(0, 0, 0));
		send_pixel(rgb(65535, 65535, 65535));
		send_pixel(rgb(65535, 0, 0));
		send_pixel(rgb(0, 65535, 0));
		send_pixel(rgb(0, 0, 65535));
		send_pixel(rgb(65535, 65535, 0));
		send_pixel(rgb(0, 65535, 65535));
		send_pixel(rgb(65535, 0, 65535));
		foreach (v[k])
			send_pixel(rgb(v[k], v[5 - k], v[(k + 2) % 6]));
		send_pixel(rgb(1, 0, 0));
		send_pixel(rgb(0, 1, 0));
		send_pixel(rgb(0, 0, 1));
		send_pixel(rgb(32768, 32768, 32768));
	endtask

	// random pixels; mix of full-range, dark and near-saturated values
	task automatic test_random(int count);
		lrgbok_pkg::pixel_t p;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 3))
				0: p = rgb($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
				1: p = rgb($urandom_range(60000, 65535), $urandom_range(0, 65535),
					$urandom_range(60000, 65535));
				default: p = rgb($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535));
			endcase
			if ($urandom_range(0, 7) == 0)
				p.blue_linear = 16'($urandom());
			send_pixel(p);
		end
	endtask

	// drain, then let the pipeline settle
	task automatic wait_drain();
		start <= 1'b0;
		while (lab_queue.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		fail_count = 0;
		idle_on    = 1'b1;
		arst_n     = 1'b0;
		start      = 1'b0;
		pixel      = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_random(1600);
		idle_on = 1'b0;
		test_random(400);
		wait_drain();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// timeout
	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

endmodule
